[src/sml_pkg.sv]
`timescale 1ns / 1ps
// smooth l1 mean loss: shared types and constants
// no dependencies

package sml_pkg;

    localparam int DATA_W = 16;
    localparam int LOSS_W = 16;
    localparam int SUM_W  = 32;
    localparam int MEAN_W = 16;
    localparam int CNT_OUT_W = 17;

    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

    typedef struct packed {
        logic signed [DATA_W-1:0] target_value;
        logic signed [DATA_W-1:0] predicted_value;
        logic                     last_element;
    } pair_t;

    typedef struct packed {
        logic [MEAN_W-1:0]    mean_loss;
        logic [CNT_OUT_W-1:0] element_count;
        logic                 count_overflow;
    } result_t;

    typedef struct packed {
        logic load;
        logic accum;
        logic div_start;
        logic capture;
    } sml_cmd_t;

    typedef struct packed {
        logic div_done;
    } sml_status_t;

endpackage

[src/sml_div.sv]
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
// depends on sml_pkg

module sml_div
    import sml_pkg::*;
#(
    parameter int DIVISOR_W = 17
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic [SUM_W-1:0]     quotient,
    output logic                 done
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIVISOR_W:0] rem_shift;
    logic [DIVISOR_W:0] rem_diff;
    logic               fits;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign fits      = (rem_shift >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[src/sml_dp.sv]
`timescale 1ns / 1ps
// datapath: per-pair loss, saturating accumulator, pair counter, mean and result register
// depends on sml_pkg and sml_div

module sml_dp
    import sml_pkg::*;
#(
    parameter int MAX_ELEMENTS = 65536,
    parameter int FRAC_BITS    = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  sml_cmd_t    cmd,
    output sml_status_t status,
    input  pair_t       pair_data,
    output result_t     loss_data
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int EXT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_ELEMENTS);
    localparam logic [DATA_W:0]   FIX_ONE  = (DATA_W + 1)'(64'd1 << FRAC_BITS);
    localparam logic [LOSS_W-1:0] FIX_HALF = LOSS_W'(64'd1 << (FRAC_BITS - 1));

    // per-pair loss
    logic signed [DATA_W:0]   diff;
    logic        [DATA_W:0]   diff_abs;
    logic        [DATA_W-1:0] mag;
    logic        [2*DATA_W-1:0] square;
    logic        [LOSS_W-1:0] loss_next;
    logic        [LOSS_W-1:0] loss_reg;

    assign diff     = (DATA_W + 1)'(pair_data.predicted_value)
                    - (DATA_W + 1)'(pair_data.target_value);
    assign diff_abs = diff[DATA_W] ? (DATA_W + 1)'(-diff) : (DATA_W + 1)'(diff);
    assign mag      = diff_abs[DATA_W-1:0];
    assign square   = (2 * DATA_W)'(mag) * (2 * DATA_W)'(mag);

    always_comb
    begin
        if ({1'b0, mag} < FIX_ONE)
            loss_next = LOSS_W'(square >> (FRAC_BITS + 1));
        else
            loss_next = mag - FIX_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            loss_reg <= loss_next;
    end

    // accumulator
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [SUM_W:0]   sum_wide;

    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(loss_reg);

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.capture)
        begin
            sum_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.accum)
        begin
            if (count_reg == CNT_MAX)
                ovf_next = 1'b1;
            else
            begin
                sum_next   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // mean
    logic [SUM_W-1:0] quotient;
    logic             div_done;

    sml_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign status.div_done = div_done;

    logic [MEAN_W-1:0] mean;
    logic [EXT_W-1:0]  count_ext;

    always_comb
    begin
        if (count_reg == '0)
            mean = '0;
        else if (|quotient[SUM_W-1:MEAN_W])
            mean = MEAN_MAX;
        else
            mean = quotient[MEAN_W-1:0];
    end

    assign count_ext = EXT_W'(count_reg);

    result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            result_reg.mean_loss      <= mean;
            result_reg.element_count  <= count_ext[CNT_OUT_W-1:0];
            result_reg.count_overflow <= ovf_reg;
        end
    end

    assign loss_data = result_reg;

endmodule

[src/sml_ctrl.sv]
`timescale 1ns / 1ps
// controller: input handshake, pair stage, end-of-set sequence, output beat valid
// depends on sml_pkg

module sml_ctrl
    import sml_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pair_valid,
    output logic        pair_stall,
    input  logic        last_element,
    output logic        loss_valid,
    input  logic        loss_stall,
    output sml_cmd_t    cmd,
    input  sml_status_t status
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_FIN  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       stage_valid_reg, stage_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       slot_free;

    assign pair_stall = (state_reg != ST_RUN);
    assign accept     = pair_valid && !pair_stall;
    assign slot_free  = !out_valid_reg || !loss_stall;

    always_comb
    begin
        state_next       = state_reg;
        cmd.load         = accept;
        cmd.accum        = stage_valid_reg;
        cmd.div_start    = 1'b0;
        cmd.capture      = 1'b0;
        stage_valid_next = accept;
        unique case (state_reg)
            ST_RUN:
            begin
                if (accept && last_element)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done && slot_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.capture)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && loss_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign loss_valid = out_valid_reg;

endmodule

[src/smooth_l1_mean_loss_unit.sv]
`timescale 1ns / 1ps
// smooth l1 (beta 1.0) mean loss unit, top level
// depends on sml_pkg, sml_ctrl, sml_dp
//
// usage:
//   pair channel (pair_valid, pair_stall, pair_data) carries one target and predicted
//   value per beat, signed fixed point with FRAC_BITS fraction bits, plus a last flag.
//   loss channel (loss_valid, loss_stall, loss_data) gives one beat per set: the
//   truncated mean loss, the pair count and a flag set when the count saturated
//   at MAX_ELEMENTS.
//   pairs without the last flag are taken one per cycle; the loss of a pair is
//   registered, then added to the saturating sum in the following cycle.
//   a pair with the last flag closes the set: pair_stall rises while the unit adds
//   the last loss, loads the divider, runs the bit-serial divider and stores the
//   result in the output register, which then presents the result beat.
//   the 32-step divider sets the per-set cost.
//   the result sits in an output register; while loss_stall is high it holds, and
//   the next set keeps accumulating. a later set that finishes waits at the
//   divider until the held beat is taken.
//   reset clears the sum, the count, the overflow flag and all valid bits.

module smooth_l1_mean_loss_unit
    import sml_pkg::*;
#(
    parameter int MAX_ELEMENTS = 65536,
    parameter int FRAC_BITS    = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pair_valid,
    output logic    pair_stall,
    input  pair_t   pair_data,
    output logic    loss_valid,
    input  logic    loss_stall,
    output result_t loss_data
);

    sml_cmd_t    cmd;
    sml_status_t status;

    sml_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .last_element (pair_data.last_element),
        .loss_valid   (loss_valid),
        .loss_stall   (loss_stall),
        .cmd          (cmd),
        .status       (status)
    );

    sml_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .pair_data (pair_data),
        .loss_data (loss_data)
    );

endmodule

[sim/tb_smooth_l1_mean_loss_unit.sv]
`timescale 1ns / 1ps
// testbench for smooth_l1_mean_loss_unit: directed and random pair sets, with an in-bench
// smooth l1 mean predictor and an in-order scoreboard on the loss channel
// depends on sml_pkg and smooth_l1_mean_loss_unit

module tb_smooth_l1_mean_loss_unit;
    import sml_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int MAX_PAIRS    = 65536;
    localparam int FRAC         = 8;
    localparam int RANDOM_PAIRS = 1700;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int REPORT_MAX   = 10;

    localparam logic [16:0] FIX_ONE  = 17'd1 << FRAC;
    localparam logic [16:0] FIX_HALF = 17'd1 << (FRAC - 1);

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    pair_valid = 1'b0;
    logic    pair_stall;
    pair_t   pair_data  = '0;
    logic    loss_valid;
    logic    loss_stall = 1'b0;
    result_t loss_data;

    // predictor state
    logic [SUM_W-1:0] model_sum       = '0;
    logic [16:0]      model_count     = '0;
    logic             model_saturated = 1'b0;

    result_t expected_losses[$];
    pair_t   pending_pairs[$];

    int burst_left       = 0;
    int gap_left         = 0;
    int hold_left        = 0;
    int holds_requested  = 0;
    int holds_served     = 0;
    int segment_left     = 0;
    int stall_pct        = 0;
    int cycle_count      = 0;
    int error_count      = 0;
    int pairs_accepted   = 0;
    int sets_checked     = 0;
    int saturated_sets   = 0;

    smooth_l1_mean_loss_unit #(
        .MAX_ELEMENTS(MAX_PAIRS),
        .FRAC_BITS   (FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair_valid(pair_valid),
        .pair_stall(pair_stall),
        .pair_data (pair_data),
        .loss_valid(loss_valid),
        .loss_stall(loss_stall),
        .loss_data (loss_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [16:0] huber_term(pair_t p);
        logic [16:0] diff;
        logic [16:0] mag;
        logic [33:0] square;
        diff = {p.predicted_value[15], p.predicted_value} - {p.target_value[15], p.target_value};
        mag = diff[16] ? (~diff + 17'd1) : diff;
        if (mag < FIX_ONE)
        begin
            square = 34'(mag) * 34'(mag);
            return 17'(square >> (FRAC + 1));
        end
        return mag - FIX_HALF;
    endfunction

    task automatic absorb_pair(pair_t p);
        logic [SUM_W:0] total;
        logic [31:0]    mean;
        result_t        r;
        if (model_count >= MAX_PAIRS)
            model_saturated = 1'b1;
        else
        begin
            total = {1'b0, model_sum} + {16'd0, huber_term(p)};
            model_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
            model_count = model_count + 17'd1;
        end
        if (p.last_element)
        begin
            mean = (model_count != 0) ? model_sum / model_count : 32'd0;
            r.mean_loss      = (mean > 32'(MEAN_MAX)) ? MEAN_MAX : mean[MEAN_W-1:0];
            r.element_count  = model_count;
            r.count_overflow = model_saturated;
            expected_losses.push_back(r);
            model_sum       = '0;
            model_count     = '0;
            model_saturated = 1'b0;
        end
    endtask

    task automatic flag_error(string what, result_t want, result_t got);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("mismatch (%s) at %0t: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                     what, $time, want.mean_loss, want.element_count, want.count_overflow,
                     got.mean_loss, got.element_count, got.count_overflow);
    endtask

    task automatic check_loss(result_t got);
        result_t want;
        if (expected_losses.size() == 0)
        begin
            flag_error("unexpected beat", '0, got);
            return;
        end
        want = expected_losses.pop_front();
        if (got.mean_loss !== want.mean_loss)
            flag_error("mean_loss", want, got);
        if (got.element_count !== want.element_count)
            flag_error("element_count", want, got);
        if (got.count_overflow !== want.count_overflow)
            flag_error("count_overflow", want, got);
        sets_checked++;
        if (want.count_overflow)
            saturated_sets++;
    endtask

    // pair sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid <= 1'b0;
            pair_data  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (pair_valid && !pair_stall)
            begin
                absorb_pair(pair_data);
                pairs_accepted++;
            end
            if (!pair_valid || !pair_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pair_valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    pair_valid <= 1'b1;
                    pair_data  <= pending_pairs.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    pair_valid <= 1'b0;
            end
        end
    end

    // loss receiver stall pattern, with long holds on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_stall <= 1'b0;
            hold_left    = 0;
            holds_served = 0;
            segment_left = 0;
            stall_pct    = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            loss_stall <= 1'b1;
        end
        else if (holds_served != holds_requested)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            loss_stall <= 1'b1;
        end
        else
        begin
            if (segment_left == 0)
            begin
                segment_left = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            segment_left--;
            loss_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // loss monitor
    always @(posedge clk)
    begin
        if (rst_n && loss_valid && !loss_stall)
            check_loss(loss_data);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_losses.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [15:0] edge_value();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'h0100;
        endcase
    endfunction

    function automatic pair_t random_pair(logic last);
        pair_t       p;
        logic [15:0] base;
        base = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                p.target_value    = edge_value();
                p.predicted_value = edge_value();
            end
            2, 3, 4, 5:
            begin
                p.target_value    = base;
                p.predicted_value = base + 16'($urandom_range(0, 600)) - 16'd300;
            end
            default:
            begin
                p.target_value    = 16'($urandom);
                p.predicted_value = 16'($urandom);
            end
        endcase
        p.last_element = last;
        return p;
    endfunction

    task automatic push_pair(logic [15:0] tgt, logic [15:0] pred, logic last);
        pair_t p;
        p.target_value    = tgt;
        p.predicted_value = pred;
        p.last_element    = last;
        pending_pairs.push_back(p);
    endtask

    task automatic push_set(int n);
        for (int i = 0; i < n; i++)
            pending_pairs.push_back(random_pair(i == n - 1));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_pairs.size() != 0 || pair_valid || expected_losses.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int  random_sent;
        int  set_size;
        bit  held;
        bit  paused;
        random_sent = 0;
        held        = 1'b0;
        paused      = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single pairs and short sets around the quadratic/linear boundary and at the range ends
        push_pair(16'h0000, 16'h0000, 1'b1);
        push_pair(16'h0000, 16'h00FF, 1'b1);
        push_pair(16'h0000, 16'h0100, 1'b1);
        push_pair(16'h0000, 16'hFEFF, 1'b1);
        push_pair(16'h8000, 16'h7FFF, 1'b1);
        push_pair(16'h7FFF, 16'h8000, 1'b1);
        push_pair(16'h7FFF, 16'h7FFF, 1'b0);
        push_pair(16'h8000, 16'h8000, 1'b0);
        push_pair(16'h0001, 16'h0000, 1'b0);
        push_pair(16'h0000, 16'hFF00, 1'b0);
        push_pair(16'h0064, 16'hFF9C, 1'b0);
        push_pair(16'h8000, 16'h0000, 1'b0);
        push_pair(16'h7FFF, 16'hFFFF, 1'b1);
        push_pair(16'hFFFF, 16'h0000, 1'b0);
        push_pair(16'h5555, 16'hAAAA, 1'b0);
        push_pair(16'hAAAA, 16'h5555, 1'b1);
        wait_idle();

        while (random_sent < RANDOM_PAIRS)
        begin
            if (!held && random_sent > 500)
            begin
                held = 1'b1;
                holds_requested++;
                for (int i = 0; i < 3; i++)
                    push_set(24);
                random_sent += 72;
            end
            else if (!paused && random_sent > 1000)
            begin
                paused = 1'b1;
                wait_idle();
            end
            set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(1, 16);
            push_set(set_size);
            random_sent += set_size;
            while (pending_pairs.size() > 64)
                @(negedge clk);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_losses.size() != 0)
        begin
            error_count += expected_losses.size();
            $display("%0d expected results never arrived", expected_losses.size());
        end
        $display("sent %0d pairs, checked %0d set results (%0d with a saturated count)",
                 pairs_accepted, sets_checked, saturated_sets);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
